/* src/dbcs_pkg.sv */
// ----------------------------------------------------------------------------
// dbcs_pkg
// Shared types, constants and helpers for the base composition counter.
// ----------------------------------------------------------------------------
package dbcs_pkg;

    // Counter width of every total
    localparam int CountWidth = 48;
    // Width and reset value of the run length register
    localparam int CfgWidth = 4;
    localparam logic [CfgWidth-1:0] CfgRunReset = 4'd8;
    // Longest run that is tracked; runs at this length or above never count
    localparam int MaxRunDefault = 15;
    // Depth of the queue between front and back
    localparam int QueueDepth = 2;

    // Input actions
    localparam logic ActSymbol = 1'b0;
    localparam logic ActEnd    = 1'b1;

    // Characters after lowering
    localparam logic [7:0] ChA    = 8'h61;
    localparam logic [7:0] ChC    = 8'h63;
    localparam logic [7:0] ChG    = 8'h67;
    localparam logic [7:0] ChT    = 8'h74;
    localparam logic [7:0] ChUpA  = 8'h41;
    localparam logic [7:0] ChUpZ  = 8'h5A;
    localparam logic [7:0] CaseOff = 8'h20;

    // Base codes, also the order of the per-base totals
    localparam logic [1:0] BaseA = 2'd0;
    localparam logic [1:0] BaseC = 2'd1;
    localparam logic [1:0] BaseG = 2'd2;
    localparam logic [1:0] BaseT = 2'd3;

    typedef enum logic [1:0] {
        KIND_BASE  = 2'd0,
        KIND_AMBIG = 2'd1,
        KIND_END   = 2'd2
    } t_kind;

    // Input request
    typedef struct packed {
        logic       action;
        logic [7:0] symbol;
    } t_item;

    // Result request
    typedef struct packed {
        logic [CountWidth-1:0] total_length;
        logic [CountWidth-1:0] ambiguous_count;
        logic [CountWidth-1:0] gc_count;
        logic [CountWidth-1:0] a_count;
        logic [CountWidth-1:0] c_count;
        logic [CountWidth-1:0] g_count;
        logic [CountWidth-1:0] t_count;
        logic [CountWidth-1:0] run_hits;
    } t_result;

    // Classified request handed from front to back
    typedef struct packed {
        t_kind      kind;
        logic [1:0] code;
        logic       is_gc;
    } t_token;

    // Saturating increment
    function automatic logic [CountWidth-1:0] sat_inc(input logic [CountWidth-1:0] v);
        return (&v) ? v : v + CountWidth'(1);
    endfunction

endpackage

/* src/dbcs_front.sv */
// ----------------------------------------------------------------------------
// dbcs_front
// Lowers incoming characters and classifies each request into a token.
// ----------------------------------------------------------------------------
module dbcs_front
    import dbcs_pkg::*;
(
    input  t_item  i_item,
    output t_token o_token
);

    logic [7:0] w_lower;

    // Lower upper-case letters
    always_comb begin
        if (i_item.symbol >= ChUpA && i_item.symbol <= ChUpZ) begin
            w_lower = i_item.symbol + CaseOff;
        end else begin
            w_lower = i_item.symbol;
        end
    end

    // Classify
    always_comb begin
        o_token.kind  = KIND_AMBIG;
        o_token.code  = BaseA;
        o_token.is_gc = 1'b0;
        if (i_item.action == ActEnd) begin
            o_token.kind = KIND_END;
        end else begin
            unique case (w_lower)
                ChA: begin
                    o_token.kind = KIND_BASE;
                    o_token.code = BaseA;
                end
                ChC: begin
                    o_token.kind  = KIND_BASE;
                    o_token.code  = BaseC;
                    o_token.is_gc = 1'b1;
                end
                ChG: begin
                    o_token.kind  = KIND_BASE;
                    o_token.code  = BaseG;
                    o_token.is_gc = 1'b1;
                end
                ChT: begin
                    o_token.kind = KIND_BASE;
                    o_token.code = BaseT;
                end
                default: begin
                    o_token.kind = KIND_AMBIG;
                end
            endcase
        end
    end

endmodule

/* src/dbcs_queue.sv */
// ----------------------------------------------------------------------------
// dbcs_queue
// Short token queue that lets the front and back stall on their own.
// ----------------------------------------------------------------------------
module dbcs_queue
    import dbcs_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_token i_data,
    output logic   o_full,
    input  logic   i_pop,
    output logic   o_empty,
    output t_token o_data
);

    localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
    localparam int CntW = $clog2(QueueDepth + 1);

    t_token            r_mem [QueueDepth];
    logic [PtrW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PtrW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CntW-1:0]   r_count,  n_count;

    assign o_full  = (r_count == CntW'(QueueDepth));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    // Advance pointers and fill count
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PtrW'(QueueDepth - 1)) ? '0 : r_wr_ptr + PtrW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PtrW'(QueueDepth - 1)) ? '0 : r_rd_ptr + PtrW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CntW'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CntW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

/* src/dbcs_back.sv */
// ----------------------------------------------------------------------------
// dbcs_back
// Updates the totals and run tracking for each token; the totals are the
// output register.
// ----------------------------------------------------------------------------
module dbcs_back
    import dbcs_pkg::*;
#(
    parameter int MAX_RUN = MaxRunDefault
)
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CfgWidth-1:0] i_cfg_data,
    input  logic                i_tok_valid,
    input  t_token              i_token,
    output logic                o_tok_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output t_result             o_result
);

    localparam int RunW = $clog2(MAX_RUN + 1);
    localparam int CmpW = (RunW > CfgWidth) ? RunW : CfgWidth;

    logic [CfgWidth-1:0]   r_cfg_run;
    logic                  r_out_vld,  n_out_vld;
    logic                  r_prev_vld, n_prev_vld;
    logic [1:0]            r_prev_code, n_prev_code;
    logic [RunW-1:0]       r_run,      n_run;
    t_result               r_tot,      n_tot;
    logic                  w_close_hit;

    assign o_valid   = r_out_vld;
    assign o_result  = r_tot;
    assign o_tok_pop = i_tok_valid && (!r_out_vld || i_ready);

    // A closed run counts when it matches the register and is below the cap
    assign w_close_hit = (r_run != '0) && (r_run < RunW'(MAX_RUN)) &&
                         (CmpW'(r_run) == CmpW'(r_cfg_run));

    // Update totals and run state for a popped token
    always_comb begin
        n_out_vld   = r_out_vld;
        n_prev_vld  = r_prev_vld;
        n_prev_code = r_prev_code;
        n_run       = r_run;
        n_tot       = r_tot;
        if (r_out_vld && i_ready) begin
            n_out_vld = 1'b0;
        end
        if (o_tok_pop) begin
            n_out_vld = 1'b1;
            case (i_token.kind)
                KIND_END: begin
                    if (w_close_hit) begin
                        n_tot.run_hits = sat_inc(r_tot.run_hits);
                    end
                    n_run      = '0;
                    n_prev_vld = 1'b0;
                end
                KIND_AMBIG: begin
                    n_tot.total_length    = sat_inc(r_tot.total_length);
                    n_tot.ambiguous_count = sat_inc(r_tot.ambiguous_count);
                    n_prev_vld            = 1'b0;
                end
                KIND_BASE: begin
                    n_tot.total_length = sat_inc(r_tot.total_length);
                    if (i_token.is_gc) begin
                        n_tot.gc_count = sat_inc(r_tot.gc_count);
                    end
                    if (r_prev_vld && (r_prev_code == i_token.code)) begin
                        if (r_run < RunW'(MAX_RUN)) begin
                            n_run = r_run + RunW'(1);
                        end
                    end else begin
                        if (w_close_hit) begin
                            n_tot.run_hits = sat_inc(r_tot.run_hits);
                        end
                        n_run = RunW'(1);
                    end
                    case (i_token.code)
                        BaseA:   n_tot.a_count = sat_inc(r_tot.a_count);
                        BaseC:   n_tot.c_count = sat_inc(r_tot.c_count);
                        BaseG:   n_tot.g_count = sat_inc(r_tot.g_count);
                        default: n_tot.t_count = sat_inc(r_tot.t_count);
                    endcase
                    n_prev_vld  = 1'b1;
                    n_prev_code = i_token.code;
                end
                default: begin
                    n_out_vld = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_run   <= CfgRunReset;
            r_out_vld   <= 1'b0;
            r_prev_vld  <= 1'b0;
            r_prev_code <= BaseA;
            r_run       <= '0;
            r_tot       <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cfg_run <= i_cfg_data;
            end
            r_out_vld   <= n_out_vld;
            r_prev_vld  <= n_prev_vld;
            r_prev_code <= n_prev_code;
            r_run       <= n_run;
            r_tot       <= n_tot;
        end
    end

endmodule

/* src/dna_base_composition_stats.sv */
// ----------------------------------------------------------------------------
// dna_base_composition_stats
// Running base composition totals and homopolymer run counts over records.
// ----------------------------------------------------------------------------
// The block takes one request per clock while the queue has room: a sequence
// character or an end of record, and returns one result per request carrying
// the current saturating totals (length, ambiguous, G+C, A, C, G, T and
// matching run count). The front classifies each request into a two-entry
// token queue; the back pops one token per cycle while its result is free or
// taken and updates the counter bank, which is itself the output register. A
// request is written into the queue, then popped into the counter bank. The
// sustained rate is one request per cycle while the result side is ready.
// Write the run length register only while no request is in flight.
module dna_base_composition_stats
    import dbcs_pkg::*;
#(
    parameter int MAX_RUN = MaxRunDefault
)
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  t_item               i_item,
    output logic                o_valid,
    input  logic                i_ready,
    output t_result             o_result,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CfgWidth-1:0] i_cfg_data
);

    t_token w_front_tok;
    t_token w_back_tok;
    logic   w_full;
    logic   w_empty;
    logic   w_pop;

    assign o_ready     = !w_full;
    assign o_cfg_ready = 1'b1;

    // Classify requests
    dbcs_front u_front (
        .i_item  (i_item),
        .o_token (w_front_tok)
    );

    // Decouple front and back
    dbcs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_valid && !w_full),
        .i_data  (w_front_tok),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_data  (w_back_tok)
    );

    // Count
    dbcs_back #(
        .MAX_RUN (MAX_RUN)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_tok_valid (!w_empty),
        .i_token     (w_back_tok),
        .o_tok_pop   (w_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_result    (o_result)
    );

endmodule

/* sim/tb_dna_base_composition_stats.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dna_base_composition_stats
// Streams sequence characters and end-of-record markers through the base
// composition counter with random idling on both sides. A local model of the
// totals and of homopolymer run tracking predicts every result, and each
// returned result is compared field by field against it.
// ----------------------------------------------------------------------------
module tb_dna_base_composition_stats;
    import dbcs_pkg::*;

    localparam int PhaseItems    = 94;
    localparam int WatchdogLimit = 2000;
    localparam int EndPause      = 8;

    // Directed stimulus row
    typedef struct {
        t_item   req;
        bit      has_golden;
        t_result golden;
    } t_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_ready;
    t_item               i_item = '0;
    logic                o_valid;
    logic                i_ready = 1'b0;
    t_result             o_result;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [CfgWidth-1:0] i_cfg_data = '0;

    // Golden result attached to the request currently presented
    bit                  row_has_golden = 1'b0;
    t_result             row_golden = '0;

    // Model state of the counter bank
    logic [CountWidth-1:0] seen_len;
    logic [CountWidth-1:0] seen_amb;
    logic [CountWidth-1:0] seen_gc;
    logic [CountWidth-1:0] seen_base [4];
    logic [CountWidth-1:0] seen_hits;
    logic [1:0]            last_base;
    bit                    last_base_ok;
    int unsigned           open_run;
    logic [CfgWidth-1:0]   run_len_cfg;

    t_result     totals_due [$];
    t_row        plan [$];
    int unsigned errors = 0;
    int unsigned accepted = 0;
    int unsigned results = 0;
    int unsigned issued = 0;
    int unsigned quiet = 0;
    int unsigned cfg_writes = 0;
    bit          calm = 1'b0;

    dna_base_composition_stats u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_item      (i_item),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Stall the result side at random, except in calm stretches
    always @(negedge i_clk) begin
        i_ready = calm || ($urandom_range(0, 99) >= 19);
    end

    function automatic logic [CountWidth-1:0] bump(input logic [CountWidth-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic logic [7:0] base_char(input logic [1:0] code, input bit upper);
        logic [7:0] ch;
        case (code)
            BaseA:   ch = ChA;
            BaseC:   ch = ChC;
            BaseG:   ch = ChG;
            default: ch = ChT;
        endcase
        return upper ? ch - CaseOff : ch;
    endfunction

    // Close the open run, counting it when its length matches the register
    task automatic close_open_run();
        if (open_run > 0 && open_run < MaxRunDefault && open_run == 32'(run_len_cfg)) begin
            seen_hits = bump(seen_hits);
        end
        open_run = 0;
    endtask

    // Advance the model by one request and return the totals it leaves
    task automatic advance_totals(input t_item req, output t_result res);
        logic [7:0] ch;
        logic [1:0] code;
        bit         is_base;
        if (req.action == ActEnd) begin
            close_open_run();
            last_base_ok = 1'b0;
        end else begin
            ch = req.symbol;
            if (ch >= ChUpA && ch <= ChUpZ) begin
                ch = ch + CaseOff;
            end
            is_base = 1'b1;
            code = BaseA;
            case (ch)
                ChA:     code = BaseA;
                ChC:     code = BaseC;
                ChG:     code = BaseG;
                ChT:     code = BaseT;
                default: is_base = 1'b0;
            endcase
            seen_len = bump(seen_len);
            if (!is_base) begin
                // ambiguous: drop the previous base, keep the run open
                seen_amb = bump(seen_amb);
                last_base_ok = 1'b0;
            end else begin
                if (code == BaseC || code == BaseG) begin
                    seen_gc = bump(seen_gc);
                end
                if (last_base_ok && code == last_base) begin
                    if (open_run < MaxRunDefault) begin
                        open_run++;
                    end
                end else begin
                    close_open_run();
                    open_run = 1;
                end
                seen_base[code] = bump(seen_base[code]);
                last_base = code;
                last_base_ok = 1'b1;
            end
        end
        res.total_length    = seen_len;
        res.ambiguous_count = seen_amb;
        res.gc_count        = seen_gc;
        res.a_count         = seen_base[BaseA];
        res.c_count         = seen_base[BaseC];
        res.g_count         = seen_base[BaseG];
        res.t_count         = seen_base[BaseT];
        res.run_hits        = seen_hits;
    endtask

    task automatic check_field(input string name, input logic [CountWidth-1:0] want,
                               input logic [CountWidth-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    task automatic compare_totals(input t_result want, input t_result got);
        check_field("total_length", want.total_length, got.total_length);
        check_field("ambiguous_count", want.ambiguous_count, got.ambiguous_count);
        check_field("gc_count", want.gc_count, got.gc_count);
        check_field("a_count", want.a_count, got.a_count);
        check_field("c_count", want.c_count, got.c_count);
        check_field("g_count", want.g_count, got.g_count);
        check_field("t_count", want.t_count, got.t_count);
        check_field("run_hits", want.run_hits, got.run_hits);
    endtask

    // Track accepted requests and register writes, check every result
    always @(posedge i_clk) begin : monitor
        t_result due;
        if (i_rst_n) begin
            quiet = quiet + 1;
            if (i_cfg_valid && o_cfg_ready) begin
                run_len_cfg = i_cfg_data;
                quiet = 0;
            end
            if (i_valid && o_ready) begin
                advance_totals(i_item, due);
                if (row_has_golden) begin
                    due = row_golden;
                end
                totals_due.push_back(due);
                accepted++;
                quiet = 0;
            end
            if (o_valid && i_ready) begin
                quiet = 0;
                results++;
                if (totals_due.size() == 0) begin
                    $error("result returned with no request outstanding");
                    errors++;
                end else begin
                    due = totals_due.pop_front();
                    compare_totals(due, o_result);
                end
            end
            if (quiet >= WatchdogLimit) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Present one request, idling first at random, and hold it until taken
    task automatic push_request(input t_item req, input bit golden, input t_result want);
        while (!calm && $urandom_range(0, 99) < 19) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_item = req;
        row_has_golden = golden;
        row_golden = want;
        @(posedge i_clk);
        while (!o_ready) begin
            @(posedge i_clk);
        end
        issued++;
        @(negedge i_clk);
    endtask

    task automatic push_plain(input logic act, input logic [7:0] sym);
        t_item req;
        req.action = act;
        req.symbol = sym;
        push_request(req, 1'b0, '0);
    endtask

    task automatic plan_row(input logic act, input logic [7:0] sym, input bit golden,
                            input t_result want);
        t_row row;
        row.req.action = act;
        row.req.symbol = sym;
        row.has_golden = golden;
        row.golden = want;
        plan.push_back(row);
    endtask

    // Wait for every result, then let the pipeline drain
    task automatic drain();
        i_valid = 1'b0;
        while (totals_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (EndPause) @(negedge i_clk);
    endtask

    task automatic write_run_len(input logic [CfgWidth-1:0] value);
        drain();
        i_cfg_valid = 1'b1;
        i_cfg_data = value;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        cfg_writes++;
    endtask

    // One random stretch of sequence: mostly homopolymer runs of mixed case
    task automatic emit_segment(input logic [CfgWidth-1:0] cfg_now);
        int unsigned pick;
        int unsigned len;
        int unsigned cut;
        logic [1:0]  code;
        pick = $urandom_range(0, 99);
        code = 2'($urandom_range(0, 3));
        if (cfg_now >= 1 && cfg_now < MaxRunDefault && $urandom_range(0, 1) == 1) begin
            len = 32'(cfg_now);
        end else begin
            len = $urandom_range(1, 18);
        end
        if (pick < 60) begin
            repeat (len) push_plain(ActSymbol, base_char(code, 1'($urandom_range(0, 1))));
        end else if (pick < 70) begin
            // run split by a random character, usually an ambiguous one
            cut = $urandom_range(1, len);
            repeat (cut) push_plain(ActSymbol, base_char(code, 1'($urandom_range(0, 1))));
            push_plain(ActSymbol, 8'($urandom_range(0, 255)));
            repeat (len - cut + 1) push_plain(ActSymbol, base_char(code, 1'b0));
        end else if (pick < 82) begin
            push_plain(ActEnd, 8'($urandom_range(0, 255)));
        end else begin
            push_plain(ActSymbol, 8'($urandom_range(0, 255)));
        end
    endtask

    initial begin : stimulus
        t_result zero_totals;
        t_result one_a;
        logic [CfgWidth-1:0] phase_cfg [8];
        int unsigned phase_start;

        zero_totals = '0;
        one_a = '0;
        one_a.total_length = 1;
        one_a.a_count = 1;

        seen_len = '0;
        seen_amb = '0;
        seen_gc = '0;
        foreach (seen_base[k]) seen_base[k] = '0;
        seen_hits = '0;
        last_base = BaseA;
        last_base_ok = 1'b0;
        open_run = 0;
        run_len_cfg = CfgRunReset;

        // Hold reset, then release it
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed table, run with the register at its reset value
        plan_row(ActEnd,    8'h00, 1'b1, zero_totals);  // empty record
        plan_row(ActSymbol, ChUpA, 1'b1, one_a);        // upper case lowered
        plan_row(ActSymbol, ChC,   1'b0, '0);
        plan_row(ActSymbol, 8'h47, 1'b0, '0);           // G
        plan_row(ActSymbol, ChT,   1'b0, '0);
        plan_row(ActSymbol, 8'h4E, 1'b0, '0);           // N
        plan_row(ActSymbol, 8'h00, 1'b0, '0);
        plan_row(ActSymbol, 8'hFF, 1'b0, '0);
        plan_row(ActSymbol, 8'h40, 1'b0, '0);           // just below A
        plan_row(ActSymbol, 8'h5B, 1'b0, '0);           // just above Z
        plan_row(ActSymbol, 8'h60, 1'b0, '0);           // just below a
        plan_row(ActSymbol, ChUpZ, 1'b0, '0);
        plan_row(ActSymbol, 8'h7B, 1'b0, '0);           // just above z
        repeat (8) plan_row(ActSymbol, ChA, 1'b0, '0);  // run of eight
        plan_row(ActSymbol, 8'h43, 1'b0, '0);           // C closes the run
        plan_row(ActSymbol, 8'h78, 1'b0, '0);           // ambiguous inside run
        plan_row(ActSymbol, ChC,   1'b0, '0);           // same base starts anew
        plan_row(ActEnd,    ChA,   1'b0, '0);           // symbol ignored
        foreach (plan[n]) begin
            push_request(plan[n].req, plan[n].has_golden, plan[n].golden);
        end

        // Random phases: reset value first, then written settings
        phase_cfg[0] = CfgRunReset;
        phase_cfg[1] = 4'd1;
        phase_cfg[2] = 4'd14;
        phase_cfg[3] = 4'd0;
        phase_cfg[4] = 4'd15;
        phase_cfg[5] = 4'd2;
        phase_cfg[6] = 4'd3;
        phase_cfg[7] = 4'($urandom_range(1, 14));
        for (int p = 0; p < 8; p++) begin
            if (p > 0) begin
                write_run_len(phase_cfg[p]);
            end
            // keep both sides busy throughout one phase
            calm = (p == 2);
            phase_start = issued;
            while (issued - phase_start < PhaseItems) begin
                emit_segment(phase_cfg[p]);
            end
        end
        calm = 1'b0;

        drain();
        $display("Sent %0d requests over %0d register settings, checked %0d results.",
                 accepted, cfg_writes + 1, results);
        $display("Final totals: %0d characters, %0d matching runs.", seen_len, seen_hits);
        if (errors == 0 && totals_due.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

/* sim.f */
src/dbcs_pkg.sv
src/dbcs_front.sv
src/dbcs_queue.sv
src/dbcs_back.sv
src/dna_base_composition_stats.sv
sim/tb_dna_base_composition_stats.sv
